[design/prs_pkg.sv]
// ----------------------------------------------------------------------------
// PRESENT cipher package
// Shared constants, types, the 4-bit S-box and the bit permutation used by
// the nibble-serial PRESENT encryption core.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int BLOCK_W   = 64;  // cipher block width
    localparam int KEY_W     = 64;  // width of one key configuration register
    localparam int ROUND_W   = 5;   // round counter width of the key schedule
    localparam int NIB_W     = 4;   // width of the index of one nibble within a block
    localparam int CFG_IDX_W = 2;   // configuration register index width

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER = 2'd2;

    // Key schedule modes.
    localparam logic MODE_KEY80  = 1'b0;
    localparam logic MODE_KEY128 = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NIB,
        S_PERM,
        S_FINAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;     // copy the configured key into the key register
        logic advance;  // take one key schedule step
    } t_ks_ctrl;

    typedef struct packed {
        logic load;     // capture the plaintext
        logic step;     // process the low nibble and rotate by one nibble
        logic sub_en;   // pass the nibble through the S-box on a step
        logic perm;     // apply the bit permutation
    } t_dp_ctrl;

    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        unique case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            default: y = 4'h2;
        endcase
        return y;
    endfunction

    // Bit i moves to bit 16*i mod 63; bit 63 stays. Pure wiring.
    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            y[(16 * i) % 63] = x[i];
        end
        y[BLOCK_W-1] = x[BLOCK_W-1];
        return y;
    endfunction

endpackage

[design/prs_key_sched.sv]
// ----------------------------------------------------------------------------
// PRESENT key schedule
// Holds the 128-bit key register, steps it once per round and hands out the
// current round key one nibble at a time.
// ----------------------------------------------------------------------------
module prs_key_sched (
    input  logic                           i_clk,
    input  prs_pkg::t_ks_ctrl              i_ctrl,
    input  logic                           i_mode,
    input  logic [prs_pkg::KEY_W-1:0]      i_key_upper,
    input  logic [prs_pkg::KEY_W-1:0]      i_key_lower,
    input  logic [prs_pkg::ROUND_W-1:0]    i_round,
    input  logic [prs_pkg::NIB_W-1:0]      i_nib_idx,
    output logic [3:0]                     o_key_nib
);
    import prs_pkg::*;

    logic [KEY_W-1:0] r_key_hi;
    logic [KEY_W-1:0] r_key_lo;
    logic [KEY_W-1:0] n_key_hi;
    logic [KEY_W-1:0] n_key_lo;
    logic [KEY_W-1:0] w_rot_hi;
    logic [KEY_W-1:0] w_rot_lo;

    always_comb begin
        w_rot_hi = r_key_hi;
        w_rot_lo = r_key_lo;
        n_key_hi = r_key_hi;
        n_key_lo = r_key_lo;
        priority if (i_ctrl.load) begin
            n_key_hi = i_key_upper;
            n_key_lo = (i_mode == MODE_KEY128) ? i_key_lower
                                               : {48'd0, i_key_lower[15:0]};
        end else if (i_ctrl.advance) begin
            if (i_mode == MODE_KEY128) begin
                w_rot_hi = {r_key_hi[2:0], r_key_lo[63:3]};
                w_rot_lo = {r_key_lo[2:0], r_key_hi[63:3]};
                n_key_hi = {sbox(w_rot_hi[63:60]), sbox(w_rot_hi[59:56]),
                            w_rot_hi[55:3], w_rot_hi[2:0] ^ i_round[4:2]};
                n_key_lo = {w_rot_lo[63:62] ^ i_round[1:0], w_rot_lo[61:0]};
            end else begin
                w_rot_hi = {r_key_hi[2:0], r_key_lo[15:0], r_key_hi[63:19]};
                w_rot_lo = {48'd0, r_key_hi[18:3]};
                n_key_hi = {sbox(w_rot_hi[63:60]), w_rot_hi[59:4],
                            w_rot_hi[3:0] ^ i_round[4:1]};
                n_key_lo = {48'd0, w_rot_lo[15] ^ i_round[0], w_rot_lo[14:0]};
            end
        end else begin
            // The key register holds its value.
            n_key_hi = r_key_hi;
            n_key_lo = r_key_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_hi <= n_key_hi;
        r_key_lo <= n_key_lo;
    end

    // The round key is the top 64 bits of the key register.
    assign o_key_nib = r_key_hi[{i_nib_idx, 2'b00} +: 4];

endmodule

[design/prs_datapath.sv]
// ----------------------------------------------------------------------------
// PRESENT data path
// A 64-bit shift register that, while stepping, adds key to one nibble per
// cycle (S-box when enabled), plus the bit permutation between rounds.
// ----------------------------------------------------------------------------
module prs_datapath (
    input  logic                           i_clk,
    input  prs_pkg::t_dp_ctrl              i_ctrl,
    input  logic [prs_pkg::BLOCK_W-1:0]    i_plaintext,
    input  logic [3:0]                     i_key_nib,
    output logic [prs_pkg::BLOCK_W-1:0]    o_state
);
    import prs_pkg::*;

    logic [BLOCK_W-1:0] r_state;
    logic [BLOCK_W-1:0] n_state;
    logic [3:0]         w_mix;
    logic [3:0]         w_nib;

    assign w_mix = r_state[3:0] ^ i_key_nib;
    assign w_nib = i_ctrl.sub_en ? sbox(w_mix) : w_mix;

    always_comb begin
        n_state = r_state;
        priority if (i_ctrl.load) begin
            n_state = i_plaintext;
        end else if (i_ctrl.step) begin
            // After sixteen steps every nibble is back in its own place.
            n_state = {w_nib, r_state[BLOCK_W-1:4]};
        end else if (i_ctrl.perm) begin
            n_state = perm_layer(r_state);
        end else begin
            // The state holds its value.
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_state = r_state;

endmodule

[design/present_block_encrypt.sv]
// ----------------------------------------------------------------------------
// PRESENT block encryption core
// Each block runs nibble-serial rounds: in a round the state is keyed and
// substituted one nibble at a time, then permuted while the key schedule
// steps; after the last round the final round key is added nibble by
// nibble. A new block is taken only once the previous result has come out.
// Reset (synchronous, active low) clears the control state and the key
// configuration; the result is a one-cycle strobe that cannot be stalled.
// ----------------------------------------------------------------------------
module present_block_encrypt #(
    parameter int ROUND_KEYS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command channel: an item is taken when start is high and busy is low.
    input  logic                                start,
    output logic                                busy,
    input  logic [prs_pkg::BLOCK_W-1:0]         i_plaintext,
    // Result strobe: one cycle, ciphertext valid in that cycle.
    output logic                                o_done,
    output logic [prs_pkg::BLOCK_W-1:0]         o_ciphertext,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [prs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [prs_pkg::KEY_W-1:0]           i_cfg_data
);
    import prs_pkg::*;

    // The round counter also feeds the key schedule, whose constant is five
    // bits wide, so the last round number must fit in five bits.
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_KEYS - 1);

    // Configuration registers.
    logic             r_key_mode;
    logic [KEY_W-1:0] r_key_upper;
    logic [KEY_W-1:0] r_key_lower;

    // Control state.
    t_state              r_state;
    t_state              n_state;
    logic [NIB_W-1:0]    r_nib;
    logic [NIB_W-1:0]    n_nib;
    logic [ROUND_W-1:0]  r_round;
    logic [ROUND_W-1:0]  n_round;
    logic [ROUND_W-1:0]  w_round_inc;

    t_ks_ctrl  w_ks_ctrl;
    t_dp_ctrl  w_dp_ctrl;
    logic [3:0] w_key_nib;
    logic       w_accept;

    assign w_accept    = start && !busy;
    assign w_round_inc = r_round + ROUND_W'(1);

    // The configuration port never pushes back. Writes to an index beyond
    // the register list are taken and dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode  <= MODE_KEY80;
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_MODE:  r_key_mode  <= i_cfg_data[0];
                CFG_KEY_UPPER: r_key_upper <= i_cfg_data;
                CFG_KEY_LOWER: r_key_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state. A round is S_NIB over all sixteen nibbles (key addition
    // and S-box, one nibble per cycle) followed by S_PERM, in which
    // the permutation and the key schedule step both happen. After the last
    // round S_FINAL adds the last round key nibble by nibble.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_NIB;
            S_NIB:   if (r_nib == '1) n_state = S_PERM;
            S_PERM:  n_state = (w_round_inc == LAST_ROUND) ? S_FINAL : S_NIB;
            S_FINAL: if (r_nib == '1) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and counter updates.
    always_comb begin
        w_ks_ctrl = '0;
        w_dp_ctrl = '0;
        n_nib     = '0;
        n_round   = r_round;
        busy      = 1'b1;
        o_done    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    w_ks_ctrl.load = 1'b1;
                    w_dp_ctrl.load = 1'b1;
                    n_round        = '0;
                end
            end
            S_NIB: begin
                w_dp_ctrl.step   = 1'b1;
                w_dp_ctrl.sub_en = 1'b1;
                n_nib            = r_nib + NIB_W'(1);
            end
            S_PERM: begin
                w_dp_ctrl.perm    = 1'b1;
                w_ks_ctrl.advance = 1'b1;
                n_round           = w_round_inc;
            end
            S_FINAL: begin
                w_dp_ctrl.step = 1'b1;
                n_nib          = r_nib + NIB_W'(1);
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nib   <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_nib   <= n_nib;
            r_round <= n_round;
        end
    end

    prs_key_sched u_key_sched (
        .i_clk       (i_clk),
        .i_ctrl      (w_ks_ctrl),
        .i_mode      (r_key_mode),
        .i_key_upper (r_key_upper),
        .i_key_lower (r_key_lower),
        .i_round     (w_round_inc),
        .i_nib_idx   (r_nib),
        .o_key_nib   (w_key_nib)
    );

    prs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_ctrl      (w_dp_ctrl),
        .i_plaintext (i_plaintext),
        .i_key_nib   (w_key_nib),
        .o_state     (o_ciphertext)
    );

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted item");

    // The result strobe lasts exactly one cycle and frees the block.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe longer than one cycle");

    // A result only comes out once every round has run.
    a_done_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_round == LAST_ROUND)
        else $error("result before the last round");

    // The round counter never passes the last round.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= LAST_ROUND)
        else $error("round counter out of range");

endmodule
